### hw/rtl/ipap_pkg.sv
// Package for the IPv4 address pool allocator: request modes, status codes,
// configuration register indices and shared types. No dependencies.
`default_nettype none
package ipap_pkg;
  localparam logic [2:0] MODE_ALLOC  = 3'd0;
  localparam logic [2:0] MODE_QUERY  = 3'd1;
  localparam logic [2:0] MODE_ADD    = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_RELOAD = 3'd4;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_DUP    = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_CROSS  = 3'd4;
  localparam logic [2:0] ST_NOHOST = 3'd5;
  localparam logic [2:0] ST_TRUNC  = 3'd6;

  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_END   = 2'd1;
  localparam logic [1:0] CFG_MASK  = 2'd2;

  typedef struct packed {
    logic [31:0] addr;
    logic [47:0] owner;
    logic        taken;
  } entry_t;
endpackage
`default_nettype wire

### hw/rtl/ipap_table.sv
// Pool entry memory: one synchronous write port, one registered read port.
// Depends on ipap_pkg for entry_t.
`default_nettype none
module ipap_table
  import ipap_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);
  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

### hw/rtl/ip_address_pool_allocator.sv
// IPv4 address pool allocator: top level with sequencer and result register.
// Depends on ipap_pkg and ipap_table.
//
// Usage: a request (in_mode, in_ip_addr, in_mac_addr) is taken on in_valid
// and in_ready. Exactly one result follows on out_valid/out_ready.
// Configuration (range start, range end, subnet mask) is written through
// cfg_valid/cfg_ready with cfg_index 0..2; the user must write it only while
// the block is idle; the block does not enforce this, cfg_ready is always high.
// Throughput: one request at a time. The entry memory has one registered read
// port, so a scan reads the table entries in order. Query and add scan once,
// allocate may scan twice; an allocate on an empty pool, a query for address
// 0, clear, an unused mode and a rejected reload answer without a scan;
// reload writes one entry per address in the range (at most POOL_DEPTH).
// Reset (rst_n, synchronous) empties the table; no clearing pass is needed as
// entries at or above the entry count are never read.
// When the receiver stalls, the result is held in the output register and a
// new request is accepted only once it has been taken.
`default_nettype none
module ip_address_pool_allocator
  import ipap_pkg::*;
#(
  parameter int POOL_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_mode,
  input  wire logic [31:0] in_ip_addr,
  input  wire logic [47:0] in_mac_addr,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [31:0]      out_ip_out,
  output logic             out_conflict,
  output logic [6:0]       out_free_count,
  output logic [6:0]       out_total_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SCAN2  = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_WRITE  = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] total_r, total_nxt, free_r, free_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          rvld_r, rvld_nxt;
  logic [AW-1:0] ridx_r, ridx_nxt;
  logic [2:0]    mode_r;
  logic [31:0]   ip_r;
  logic [47:0]   mac_r;
  logic [31:0]   start_r, end_r, mask_r;
  logic [31:0]   fill_r, fill_nxt, last_r, last_nxt;
  logic          dup_r, dup_nxt;
  logic [AW-1:0] pick_r, pick_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [31:0]   ipo_r, ipo_nxt;
  logic          conf_r, conf_nxt;
  logic          ovld_r, ovld_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, rd_data;

  ipap_table #(.DEPTH(POOL_DEPTH), .AW(AW)) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_ready        = (state_r == S_IDLE) && !ovld_r;
  assign cfg_ready       = 1'b1;
  assign out_valid       = ovld_r;
  assign out_status      = status_r;
  assign out_ip_out      = ipo_r;
  assign out_conflict    = conf_r;
  assign out_free_count  = 7'(free_r);
  assign out_total_count = 7'(total_r);
  assign rd_addr         = idx_r[AW-1:0];

  logic [31:0] net_w, bc_w;
  logic [32:0] first_w, last_w;
  assign net_w   = start_r & mask_r;
  assign bc_w    = start_r | ~mask_r;
  assign first_w = {1'b0, start_r} + ((net_w == start_r) ? 33'd1 : 33'd0);
  assign last_w  = (end_r == bc_w) ? ({1'b0, end_r} - 33'd1) : {1'b0, end_r};

  always_ff @(posedge clk) begin
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START: start_r <= cfg_data;
        CFG_END:   end_r   <= cfg_data;
        CFG_MASK:  mask_r  <= cfg_data;
        default: ;
      endcase
    end
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= '0;
      mask_r  <= '0;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    total_nxt  = total_r;
    free_nxt   = free_r;
    idx_nxt    = idx_r;
    rvld_nxt   = 1'b0;
    ridx_nxt   = idx_r[AW-1:0];
    fill_nxt   = fill_r;
    last_nxt   = last_r;
    dup_nxt    = dup_r;
    pick_nxt   = pick_r;
    status_nxt = status_r;
    ipo_nxt    = ipo_r;
    conf_nxt   = conf_r;
    ovld_nxt   = ovld_r && !out_ready;
    wr_en      = 1'b0;
    wr_addr    = idx_r[AW-1:0];
    wr_data    = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          status_nxt = ST_OK;
          ipo_nxt    = '0;
          conf_nxt   = 1'b0;
          idx_nxt    = '0;
          dup_nxt    = 1'b0;
          case (in_mode)
            MODE_ALLOC: begin
              if (free_r == '0) begin
                status_nxt = ST_EMPTY;
                ovld_nxt   = 1'b1;
              end else if (in_ip_addr == '0) begin
                state_nxt = S_SCAN2;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            MODE_QUERY: begin
              if (in_ip_addr == '0) ovld_nxt = 1'b1;
              else state_nxt = S_SCAN;
            end
            MODE_ADD: state_nxt = S_SCAN;
            MODE_CLEAR: begin
              total_nxt = '0;
              free_nxt  = '0;
              ovld_nxt  = 1'b1;
            end
            MODE_RELOAD: begin
              // an end of zero that is its own broadcast address underflows
              if ((end_r & mask_r) != net_w) begin
                status_nxt = ST_CROSS;
                ovld_nxt   = 1'b1;
              end else if ((first_w > last_w) || last_w[32]) begin
                status_nxt = ST_NOHOST;
                ovld_nxt   = 1'b1;
              end else begin
                total_nxt = '0;
                free_nxt  = '0;
                fill_nxt  = first_w[31:0];
                last_nxt  = last_w[31:0];
                state_nxt = S_FILL;
              end
            end
            default: ovld_nxt = 1'b1;
          endcase
        end
      end
      // Scan for a match: free entry with the address (S_SCAN2: any free entry),
      // taken entry for a query, any entry for add; read at idx, checked next cycle.
      S_SCAN, S_SCAN2: begin
        if (idx_r < total_r && !dup_r) begin
          rvld_nxt = 1'b1;
          idx_nxt  = idx_r + 1'b1;
        end
        if (rvld_r && !dup_r) begin
          if (state_r == S_SCAN2 ? !rd_data.taken :
              (mode_r == MODE_ALLOC ? (!rd_data.taken && rd_data.addr == ip_r) :
               mode_r == MODE_QUERY ? (rd_data.taken && rd_data.addr == ip_r) :
               (rd_data.addr == ip_r))) begin
            dup_nxt  = 1'b1;
            pick_nxt = ridx_r;
            ipo_nxt  = rd_data.addr;
            conf_nxt = rd_data.owner != mac_r;
            rvld_nxt = 1'b0;
          end
        end
        if (dup_nxt || (idx_r >= total_r && !rvld_r)) begin
          rvld_nxt = 1'b0;
          state_nxt = S_RESULT;
          if (!dup_nxt && state_r == S_SCAN && mode_r == MODE_ALLOC) begin
            state_nxt = S_SCAN2;
            idx_nxt   = '0;
          end
        end
      end
      S_RESULT: begin
        state_nxt = S_IDLE;
        ovld_nxt  = 1'b1;
        case (mode_r)
          MODE_ALLOC: begin
            if (dup_r) begin
              wr_en    = 1'b1;
              wr_addr  = pick_r;
              wr_data  = '{addr: ipo_r, owner: mac_r, taken: 1'b1};
              free_nxt = free_r - 1'b1;
            end else begin
              status_nxt = ST_EMPTY;
              ipo_nxt    = '0;
            end
            conf_nxt = 1'b0;
          end
          MODE_QUERY: begin
            conf_nxt = dup_r & conf_r;
            ipo_nxt  = '0;
          end
          default: begin
            ipo_nxt  = '0;
            conf_nxt = 1'b0;
            if (dup_r) begin
              status_nxt = ST_DUP;
            end else if (total_r >= CW'(POOL_DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = total_r[AW-1:0];
              wr_data   = '{addr: ip_r, owner: '0, taken: 1'b0};
              total_nxt = total_r + 1'b1;
              free_nxt  = free_r + 1'b1;
            end
          end
        endcase
      end
      S_FILL: begin
        if (total_r >= CW'(POOL_DEPTH)) begin
          status_nxt = ST_TRUNC;
          state_nxt  = S_IDLE;
          ovld_nxt   = 1'b1;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = total_r[AW-1:0];
          wr_data   = '{addr: fill_r, owner: '0, taken: 1'b0};
          total_nxt = total_r + 1'b1;
          free_nxt  = free_r + 1'b1;
          fill_nxt  = fill_r + 32'd1;
          if (fill_r == last_r) state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        state_nxt = S_IDLE;
        ovld_nxt  = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      free_r  <= '0;
      ovld_r  <= 1'b0;
      rvld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      free_r  <= free_nxt;
      ovld_r  <= ovld_nxt;
      rvld_r  <= rvld_nxt;
    end
    idx_r    <= idx_nxt;
    ridx_r   <= ridx_nxt;
    fill_r   <= fill_nxt;
    last_r   <= last_nxt;
    dup_r    <= dup_nxt;
    pick_r   <= pick_nxt;
    status_r <= status_nxt;
    ipo_r    <= ipo_nxt;
    conf_r   <= conf_nxt;
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      ip_r   <= in_ip_addr;
      mac_r  <= in_mac_addr;
    end
  end

`ifndef SYNTH
  a_free_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= total_r) else $error("free count above entry count");
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CW'(POOL_DEPTH)) else $error("entry count above depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("request taken while busy");
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovld_r) |-> state_r == S_IDLE) else $error("result raised mid-request");
`endif
endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for ip_address_pool_allocator: random and directed requests
// checked against a behavioural pool model held here. Depends on ipap_pkg and the RTL.
module testbench;
  import ipap_pkg::*;

  localparam int DEPTH = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE = 200;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] ip;
    logic [47:0] mac;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] ip_out;
    logic        conflict;
    logic [6:0]  free_count;
    logic [6:0]  total_count;
  } grant_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready;
  logic [2:0] in_mode = '0;
  logic [31:0] in_ip_addr = '0;
  logic [47:0] in_mac_addr = '0;
  logic out_valid, out_ready = 0;
  logic [2:0] out_status;
  logic [31:0] out_ip_out;
  logic out_conflict;
  logic [6:0] out_free_count, out_total_count;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  ip_address_pool_allocator DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // pool model
  logic [31:0] pool_addr [DEPTH];
  logic [47:0] pool_owner [DEPTH];
  logic        pool_taken [DEPTH];
  int unsigned pool_total = 0, pool_free = 0;
  logic [31:0] range_lo = '0, range_hi = '0, range_mask = '0;

  request_t pending_requests[$];
  grant_t   expected_grants[$];
  request_t cur_request;
  int unsigned send_idle_pct = 0, recv_stall_pct = 0;
  int unsigned fail_count = 0;
  bit hold_go = 0, hold_seen = 0;
  int unsigned hold_len = 0, hold_cnt = 0;
  int unsigned quiet_cycles = 0;
  logic [47:0] mac_set [4];

  function automatic bit pool_holds(logic [31:0] a);
    for (int i = 0; i < pool_total; i++)
      if (pool_addr[i] == a) return 1;
    return 0;
  endfunction

  function automatic logic [2:0] pool_append(logic [31:0] a);
    if (pool_holds(a)) return ST_DUP;
    if (pool_total >= DEPTH) return ST_FULL;
    pool_addr[pool_total] = a;
    pool_owner[pool_total] = '0;
    pool_taken[pool_total] = 0;
    pool_total++;
    pool_free++;
    return ST_OK;
  endfunction

  function automatic logic [2:0] pool_rebuild();
    logic [31:0] net, bcast;
    longint first, last, a;
    net = range_lo & range_mask;
    bcast = range_lo | ~range_mask;
    if ((range_hi & range_mask) != net) return ST_CROSS;
    first = longint'({32'd0, range_lo}) + ((net == range_lo) ? 1 : 0);
    last = longint'({32'd0, range_hi}) - ((range_hi == bcast) ? 1 : 0);
    if (first > last) return ST_NOHOST;
    pool_total = 0;
    pool_free = 0;
    for (a = first; a <= last && pool_total < DEPTH; a++) void'(pool_append(a[31:0]));
    return (last - first + 1 > DEPTH) ? ST_TRUNC : ST_OK;
  endfunction

  function automatic grant_t apply_request(request_t r);
    grant_t g;
    int pick;
    g = '0;
    pick = -1;
    case (r.mode)
      MODE_ALLOC: begin
        if (pool_free == 0) begin
          g.status = ST_EMPTY;
        end else begin
          if (r.ip != 0)
            for (int i = 0; i < pool_total; i++)
              if (!pool_taken[i] && pool_addr[i] == r.ip && pick < 0) pick = i;
          for (int i = 0; i < pool_total; i++)
            if (!pool_taken[i] && pick < 0) pick = i;
          if (pick < 0) begin
            g.status = ST_EMPTY;
          end else begin
            pool_taken[pick] = 1;
            pool_owner[pick] = r.mac;
            pool_free--;
            g.ip_out = pool_addr[pick];
          end
        end
      end
      MODE_QUERY: begin
        if (r.ip != 0)
          for (int i = 0; i < pool_total; i++)
            if (pool_taken[i] && pool_addr[i] == r.ip && pick < 0) pick = i;
        if (pick >= 0) g.conflict = (pool_owner[pick] != r.mac);
      end
      MODE_ADD: g.status = pool_append(r.ip);
      MODE_CLEAR: begin
        pool_total = 0;
        pool_free = 0;
      end
      MODE_RELOAD: g.status = pool_rebuild();
      default: ;
    endcase
    g.free_count = pool_free[6:0];
    g.total_count = pool_total[6:0];
    return g;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && in_ready) expected_grants.push_back(apply_request(cur_request));
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_request = pending_requests.pop_front();
          in_valid <= 1;
          in_mode <= cur_request.mode;
          in_ip_addr <= cur_request.ip;
          in_mac_addr <= cur_request.mac;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          report("unexpected result", out_status, 0);
        end else begin
          want = expected_grants.pop_front();
          if (out_status !== want.status) report("status", out_status, want.status);
          if (out_ip_out !== want.ip_out) report("ip_out", out_ip_out, want.ip_out);
          if (out_conflict !== want.conflict) report("conflict", out_conflict, want.conflict);
          if (out_free_count !== want.free_count)
            report("free_count", out_free_count, want.free_count);
          if (out_total_count !== want.total_count)
            report("total_count", out_total_count, want.total_count);
        end
      end
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        hold_cnt = hold_len;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      CFG_START: range_lo = data;
      CFG_END:   range_hi = data;
      default:   range_mask = data;
    endcase
  endtask

  task automatic set_range(logic [31:0] s, logic [31:0] e, logic [31:0] m);
    write_reg(CFG_START, s);
    write_reg(CFG_END, e);
    write_reg(CFG_MASK, m);
  endtask

  task automatic random_range();
    logic [31:0] m, s, e;
    if ($urandom_range(9) == 0) begin
      set_range($urandom, $urandom, $urandom);
    end else begin
      m = 32'hffff_ffff << $urandom_range(2, 12);
      s = ($urandom & m) + $urandom_range(0, 3);
      e = ($urandom_range(4) == 0) ? (s | ~m) : s + $urandom_range(0, 90);
      set_range(s, e, m);
    end
  endtask

  // sample at the falling edge so the driver's updates have settled
  task automatic wait_idle();
    while (pending_requests.size() != 0 || expected_grants.size() != 0 || in_valid)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push(logic [2:0] mode, logic [31:0] ip, logic [47:0] mac);
    request_t r;
    r.mode = mode;
    r.ip = ip;
    r.mac = mac;
    pending_requests.push_back(r);
  endtask

  task automatic push_random();
    int unsigned roll;
    logic [2:0] mode;
    logic [31:0] ip;
    logic [47:0] mac;
    roll = $urandom_range(99);
    mode = (roll < 40) ? MODE_ALLOC : (roll < 60) ? MODE_QUERY : (roll < 85) ? MODE_ADD :
           (roll < 89) ? MODE_CLEAR : (roll < 95) ? MODE_RELOAD :
           3'($urandom_range(MODE_RELOAD + 1, 7));
    roll = $urandom_range(99);
    ip = (roll < 70) ? range_lo + $urandom_range(0, 20) : (roll < 80) ? 32'd0 : $urandom;
    mac = ($urandom_range(3) != 0) ? mac_set[$urandom_range(3)] :
          48'({$urandom, $urandom});
    push(mode, ip, mac);
  endtask

  initial begin
    mac_set[0] = '0;
    mac_set[1] = '1;
    mac_set[2] = 48'({$urandom, $urandom});
    mac_set[3] = 48'({$urandom, $urandom});
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // empty pool, unused modes, zero query, add order, address zero granted
    push(MODE_ALLOC, 32'h0a00_0001, '1);
    push(MODE_QUERY, 32'd0, '0);
    push(MODE_RELOAD, '0, '0);
    push(3'd5, '1, '1);
    push(3'd6, '0, '0);
    push(3'd7, '1, '0);
    push(MODE_ADD, 32'd0, '0);
    push(MODE_ADD, 32'd0, '1);
    push(MODE_ADD, 32'hffff_ffff, '0);
    push(MODE_ALLOC, 32'hffff_ffff, 48'hffff_ffff_ffff);
    push(MODE_ALLOC, 32'd0, 48'h1234_5678_9abc);
    push(MODE_ALLOC, 32'hffff_ffff, 48'h1);
    push(MODE_QUERY, 32'hffff_ffff, 48'h1);
    push(MODE_QUERY, 32'hffff_ffff, 48'hffff_ffff_ffff);
    push(MODE_QUERY, 32'd0, 48'h1234_5678_9abc);
    push(MODE_CLEAR, '1, '1);
    push(MODE_ALLOC, 32'd0, '0);
    wait_idle();

    // truncated reload, then full and duplicate adds
    set_range(32'hc0a8_0100, 32'hc0a8_01ff, 32'hffff_ff00);
    push(MODE_RELOAD, '0, '0);
    push(MODE_ADD, 32'hc0a8_0101, '0);
    push(MODE_ADD, 32'h0a0a_0a0a, '0);
    push(MODE_ALLOC, 32'hc0a8_0120, 48'h5);
    wait_idle();
    set_range(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    push(MODE_RELOAD, '0, '0);
    wait_idle();
    set_range(32'h0, 32'h0, 32'hffff_ffff);
    push(MODE_RELOAD, '0, '0);
    wait_idle();
    set_range(32'h0a00_0010, 32'h0a00_0110, 32'hffff_ff00);
    push(MODE_RELOAD, '0, '0);
    wait_idle();
    set_range(32'h0a00_0005, 32'h0a00_0014, 32'hffff_ff00);
    push(MODE_RELOAD, '0, '0);
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 59 : (phase == 3) ? 20 : 0;
      recv_stall_pct = (phase == 2) ? 59 : (phase == 3) ? 20 : 0;
      for (int part = 0; part < 2; part++) begin
        random_range();
        push(MODE_RELOAD, '0, '0);
        if (phase == 0 && part == 1) begin
          // hold the result port so the block backs up its input
          hold_len = 600;
          hold_go = ~hold_go;
        end
        for (int n = 0; n < 128; n++) push_random();
        wait_idle();
      end
    end

    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
